// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by pebe_back
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHECK_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication
`define CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ----- hw/rtl/pebe_pkg.sv -----
// types, codes and defaults of the pulse event bytecode encoder
// no dependencies
package pebe_pkg;

    localparam int SYNTH_CHANNELS_DEF = 22;
    localparam int DAC_CHANNELS_DEF   = 4;
    localparam int TTL_LINES_DEF      = 32;
    localparam int JOB_DEPTH          = 2;
    localparam int RES_DEPTH          = 2;

    localparam logic [2:0] CMD_TTL_WORD   = 3'd0;
    localparam logic [2:0] CMD_TTL_BIT    = 3'd1;
    localparam logic [2:0] CMD_FREQ       = 3'd2;
    localparam logic [2:0] CMD_AMP        = 3'd3;
    localparam logic [2:0] CMD_DAC        = 3'd4;
    localparam logic [2:0] CMD_CLOCK      = 3'd5;
    localparam logic [2:0] CMD_WAIT_UNTIL = 3'd6;

    localparam logic [3:0] OP_TTLALL    = 4'd0;
    localparam logic [3:0] OP_TTL2      = 4'd1;
    localparam logic [3:0] OP_TTL4      = 4'd2;
    localparam logic [3:0] OP_TTL5      = 4'd3;
    localparam logic [3:0] OP_WAIT      = 4'd4;
    localparam logic [3:0] OP_WAIT2     = 4'd5;
    localparam logic [3:0] OP_CLOCK     = 4'd6;
    localparam logic [3:0] OP_FREQ      = 4'd7;
    localparam logic [3:0] OP_AMP       = 4'd8;
    localparam logic [3:0] OP_FREQ_D7   = 4'd9;
    localparam logic [3:0] OP_FREQ_D15  = 4'd10;
    localparam logic [3:0] OP_FREQ_D23  = 4'd11;
    localparam logic [3:0] OP_AMP_D7    = 4'd12;
    localparam logic [3:0] OP_DAC       = 4'd13;
    localparam logic [3:0] OP_DAC_D10   = 4'd14;

    localparam logic [60:0] GAP_MAX = '1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] event_time;
        logic [4:0]  channel;
        logic [31:0] value;
    } item_t;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [3:0]  delay_field;
        logic [4:0]  chan_field;
        logic [31:0] payload;
        logic [4:0]  bit_a;
        logic [4:0]  bit_b;
        logic [4:0]  bit_c;
        logic [4:0]  bit_d;
        logic [4:0]  bit_e;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [60:0] gap;
        logic        has_inst;
        logic        wait_until;
        logic [3:0]  inst_slack;
        result_t     inst;
    } job_t;

endpackage

// ----- hw/rtl/pulse_event_bytecode_encoder.sv -----
// top level of the pulse event bytecode encoder
// depends on pebe_pkg, pebe_fifo, pebe_front and pebe_back
//
// Events enter through a queue-style port and come out as sequencer instruction
// words, each event giving zero or more words with last set on its final one.
// The front end holds one event at a time, showing full until it is passed on as
// a job or dropped. The back end fetches a job, splits its gap into waits (one
// exponent digit per cycle), then steps through the held word, the sixteen wait
// slots, the short wait and the instruction itself, holding a due word while the
// result queue is full. A timed digital instruction is held back until the next
// instruction or wait-until event, so its word appears with that later event.
module pulse_event_bytecode_encoder #(
    parameter int SYNTH_CHANNELS = pebe_pkg::SYNTH_CHANNELS_DEF,
    parameter int DAC_CHANNELS   = pebe_pkg::DAC_CHANNELS_DEF,
    parameter int TTL_LINES      = pebe_pkg::TTL_LINES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pebe_pkg::item_t   item,
    input  logic              push,
    output logic              full,
    input  logic              mask_we,
    input  logic [31:0]       mask_wdata,
    output pebe_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);
    import pebe_pkg::*;

    job_t    fe_job, be_job;
    logic    job_push, job_full, job_pop, job_empty;
    result_t be_res;
    logic    res_push, res_full;

    pebe_front #(
        .SYNTH_CHANNELS(SYNTH_CHANNELS),
        .DAC_CHANNELS  (DAC_CHANNELS),
        .TTL_LINES     (TTL_LINES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .mask_we   (mask_we),
        .mask_wdata(mask_wdata),
        .job       (fe_job),
        .job_push  (job_push),
        .job_full  (job_full)
    );

    pebe_fifo #(
        .WIDTH($bits(job_t)),
        .DEPTH(JOB_DEPTH)
    ) u_job_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (job_push),
        .wdata(fe_job),
        .full (job_full),
        .pop  (job_pop),
        .rdata(be_job),
        .empty(job_empty)
    );

    pebe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (be_job),
        .job_empty(job_empty),
        .job_pop  (job_pop),
        .res      (be_res),
        .res_push (res_push),
        .res_full (res_full)
    );

    pebe_fifo #(
        .WIDTH($bits(result_t)),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(be_res),
        .full (res_full),
        .pop  (pop),
        .rdata(result),
        .empty(empty)
    );

endmodule

// ----- hw/rtl/pebe_fifo.sv -----
// small first-in first-out queue of packed words
// no package dependencies
module pebe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/pebe_front.sv -----
// front end: accepts events, keeps channel state and time, builds jobs
// depends on pebe_pkg
module pebe_front #(
    parameter int SYNTH_CHANNELS = 22,
    parameter int DAC_CHANNELS   = 4,
    parameter int TTL_LINES      = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pebe_pkg::item_t item,
    input  logic           push,
    output logic           full,
    input  logic           mask_we,
    input  logic [31:0]    mask_wdata,
    output pebe_pkg::job_t job,
    output logic           job_push,
    input  logic           job_full
);
    import pebe_pkg::*;

    localparam int SCW = (SYNTH_CHANNELS > 1) ? $clog2(SYNTH_CHANNELS) : 1;
    localparam int DCW = (DAC_CHANNELS > 1) ? $clog2(DAC_CHANNELS) : 1;
    localparam logic [31:0] LINE_MASK = 32'((64'd1 << TTL_LINES) - 64'd1);

    item_t       item_reg;
    logic        busy_reg;
    logic [31:0] mask_reg;
    logic [63:0] time_reg;
    logic [31:0] ttl_reg;
    logic        ttl_wr_reg;
    logic [30:0] freq_reg [SYNTH_CHANNELS];
    logic [11:0] amp_reg  [SYNTH_CHANNELS];
    logic        freq_wr_reg [SYNTH_CHANNELS];
    logic        amp_wr_reg  [SYNTH_CHANNELS];
    logic [15:0] dac_reg  [DAC_CHANNELS];
    logic        dac_wr_reg  [DAC_CHANNELS];

    logic [63:0] gap_raw;
    logic [60:0] gap;
    logic [31:0] en, cur_m, ttl_new, changes, cw;
    logic [5:0]  nchg;
    logic [4:0]  bits [5];
    logic [SCW-1:0] sci;
    logic [DCW-1:0] dci;
    logic [30:0] fr;
    logic [31:0] fd;
    logic [11:0] av;
    logic [15:0] ad, dv, dd;
    logic        drop, go, ttl_touch;
    logic [5:0]  dur;
    result_t     inst;
    logic [3:0]  slack;

    function automatic logic [4:0] lowest(input logic [31:0] x);
        logic [4:0] n;
        n = 5'd31;
        for (int k = 31; k >= 0; k--)
        begin
            if (x[k])
            begin
                n = 5'(k);
            end
        end
        return n;
    endfunction

    assign full = busy_reg;
    assign sci  = item_reg.channel[SCW-1:0];
    assign dci  = item_reg.channel[DCW-1:0];

    always_comb
    begin
        gap_raw = (item_reg.event_time > time_reg) ? item_reg.event_time - time_reg : '0;
        gap     = (gap_raw > {3'b0, GAP_MAX}) ? GAP_MAX : gap_raw[60:0];
        en      = mask_reg & LINE_MASK;
        cur_m   = ttl_reg & en;
        if (item_reg.cmd == CMD_TTL_WORD)
        begin
            ttl_new = item_reg.value & ~32'd1 & en;
        end
        else if (item_reg.value != '0)
        begin
            ttl_new = (ttl_reg | (32'd1 << item_reg.channel)) & en;
        end
        else
        begin
            ttl_new = (ttl_reg & ~(32'd1 << item_reg.channel)) & en;
        end
        changes = ttl_wr_reg ? (ttl_new ^ cur_m) : ttl_new;
        nchg    = 6'($countones(changes));
        cw      = changes;
        for (int k = 0; k < 5; k++)
        begin
            if (cw != '0)
            begin
                bits[k] = lowest(cw);
                cw      = cw & (cw - 32'd1);
            end
            else
            begin
                bits[k] = (k > 0) ? bits[(k > 0) ? k - 1 : 0] : 5'd0;
            end
        end

        fr = (item_reg.value > 32'h7fffffff) ? 31'h7fffffff : item_reg.value[30:0];
        fd = {1'b0, fr} - {1'b0, freq_reg[sci]};
        av = (item_reg.value > 32'd4095) ? 12'd4095 : item_reg.value[11:0];
        ad = {4'b0, av} - {4'b0, amp_reg[sci]};
        dv = (item_reg.value > 32'hffff) ? 16'hffff : item_reg.value[15:0];
        dd = dv - dac_reg[dci];

        inst      = '0;
        slack     = '0;
        drop      = 1'b0;
        dur       = '0;
        ttl_touch = 1'b0;
        case (item_reg.cmd)
            CMD_TTL_WORD, CMD_TTL_BIT:
            begin
                if (item_reg.cmd == CMD_TTL_BIT && {1'b0, item_reg.channel} >= 6'(TTL_LINES))
                begin
                    drop = 1'b1;
                end
                else
                begin
                    ttl_touch = 1'b1;
                    drop      = (ttl_new == cur_m) && ttl_wr_reg;
                    dur       = 6'd3;
                    if (nchg == 6'd1 || nchg == 6'd2)
                    begin
                        inst.opcode = OP_TTL2;
                        inst.bit_a  = bits[0];
                        inst.bit_b  = bits[1];
                        slack       = 4'd3;
                    end
                    else if (nchg == 6'd3 || nchg == 6'd4)
                    begin
                        inst.opcode = OP_TTL4;
                        inst.bit_a  = bits[0];
                        inst.bit_b  = bits[1];
                        inst.bit_c  = bits[2];
                        inst.bit_d  = bits[3];
                    end
                    else if (nchg == 6'd5)
                    begin
                        inst.opcode = OP_TTL5;
                        inst.bit_a  = bits[0];
                        inst.bit_b  = bits[1];
                        inst.bit_c  = bits[2];
                        inst.bit_d  = bits[3];
                        inst.bit_e  = bits[4];
                        slack       = 4'd7;
                    end
                    else
                    begin
                        inst.opcode  = OP_TTLALL;
                        inst.payload = ttl_new;
                        slack        = 4'd15;
                    end
                end
            end
            CMD_FREQ:
            begin
                drop            = ({1'b0, item_reg.channel} >= 6'(SYNTH_CHANNELS))
                                  || (freq_wr_reg[sci] && fr == freq_reg[sci]);
                dur             = 6'd50;
                inst.chan_field = item_reg.channel;
                if (fd <= 32'h3f || fd >= 32'hffffffc0)
                begin
                    inst.opcode  = OP_FREQ_D7;
                    inst.payload = fd & 32'h7f;
                end
                else if (fd <= 32'h3fff || fd >= 32'hffffc000)
                begin
                    inst.opcode  = OP_FREQ_D15;
                    inst.payload = fd & 32'h7fff;
                end
                else if (fd <= 32'h003fffff || fd >= 32'hffc00000)
                begin
                    inst.opcode  = OP_FREQ_D23;
                    inst.payload = fd & 32'h7fffff;
                end
                else
                begin
                    inst.opcode  = OP_FREQ;
                    inst.payload = {1'b0, fr};
                end
            end
            CMD_AMP:
            begin
                drop            = ({1'b0, item_reg.channel} >= 6'(SYNTH_CHANNELS))
                                  || (amp_wr_reg[sci] && av == amp_reg[sci]);
                dur             = 6'd50;
                inst.chan_field = item_reg.channel;
                if (ad <= 16'h3f || ad >= 16'hffc0)
                begin
                    inst.opcode  = OP_AMP_D7;
                    inst.payload = {25'b0, ad[6:0]};
                end
                else
                begin
                    inst.opcode  = OP_AMP;
                    inst.payload = {20'b0, av};
                end
            end
            CMD_DAC:
            begin
                drop            = ({1'b0, item_reg.channel} >= 6'(DAC_CHANNELS))
                                  || (dac_wr_reg[dci] && dv == dac_reg[dci]);
                dur             = 6'd45;
                inst.chan_field = {3'b0, item_reg.channel[1:0]};
                if (dd <= 16'h1ff || dd >= 16'hfe00)
                begin
                    inst.opcode  = OP_DAC_D10;
                    inst.payload = {22'b0, dd[9:0]};
                end
                else
                begin
                    inst.opcode  = OP_DAC;
                    inst.payload = {16'b0, dv};
                end
            end
            CMD_CLOCK:
            begin
                dur          = 6'd5;
                inst.opcode  = OP_CLOCK;
                inst.payload = {24'b0, item_reg.value[7:0] - 8'd1};
            end
            CMD_WAIT_UNTIL:
            begin
                dur = '0;
            end
            default:
            begin
                drop = 1'b1;
            end
        endcase

        job.gap        = gap;
        job.has_inst   = (item_reg.cmd != CMD_WAIT_UNTIL);
        job.wait_until = (item_reg.cmd == CMD_WAIT_UNTIL);
        job.inst_slack = slack;
        job.inst       = inst;
    end

    assign go       = busy_reg && (drop || !job_full);
    assign job_push = busy_reg && !drop && !job_full;

    always_ff @(posedge clk)
    begin
        if (push && !busy_reg)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            mask_reg   <= 32'd1;
            time_reg   <= '0;
            ttl_reg    <= '0;
            ttl_wr_reg <= 1'b0;
            for (int k = 0; k < SYNTH_CHANNELS; k++)
            begin
                freq_reg[k]    <= '0;
                amp_reg[k]     <= '0;
                freq_wr_reg[k] <= 1'b0;
                amp_wr_reg[k]  <= 1'b0;
            end
            for (int k = 0; k < DAC_CHANNELS; k++)
            begin
                dac_reg[k]    <= '0;
                dac_wr_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (mask_we)
            begin
                mask_reg <= mask_wdata;
            end
            if (push && !busy_reg)
            begin
                busy_reg <= 1'b1;
            end
            else if (go)
            begin
                busy_reg <= 1'b0;
                if (ttl_touch)
                begin
                    ttl_reg <= drop ? cur_m : ttl_new;
                end
                if (!drop)
                begin
                    time_reg <= time_reg + {3'b0, gap} + {58'b0, dur};
                    case (item_reg.cmd)
                        CMD_TTL_WORD, CMD_TTL_BIT:
                        begin
                            ttl_wr_reg <= 1'b1;
                        end
                        CMD_FREQ:
                        begin
                            freq_reg[sci]    <= fr;
                            freq_wr_reg[sci] <= 1'b1;
                        end
                        CMD_AMP:
                        begin
                            amp_reg[sci]    <= av;
                            amp_wr_reg[sci] <= 1'b1;
                        end
                        CMD_DAC:
                        begin
                            dac_reg[dci]    <= dv;
                            dac_wr_reg[dci] <= 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

endmodule

// ----- hw/rtl/pebe_back.sv -----
// back end: splits gaps into waits, folds slack, emits result words
// depends on pebe_pkg and assert_macros.svh
module pebe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  pebe_pkg::job_t   job,
    input  logic             job_empty,
    output logic             job_pop,
    output pebe_pkg::result_t res,
    output logic             res_push,
    input  logic             res_full
);
    import pebe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SPLIT, S_HELD, S_WAIT, S_SHORT, S_MAIN
    } state_t;

    state_t      state_reg;
    job_t        job_reg;
    logic [60:0] dt_reg;
    logic [3:0]  idx_reg;
    logic [15:0] times_reg [16];
    logic [15:0] tmask_reg;
    logic [10:0] short_reg;
    logic        short_v_reg;
    result_t     held_reg;
    logic        held_v_reg;
    logic [3:0]  slack_reg;

    logic [5:0]  sh;
    logic [63:0] thr, lowm;
    logic [60:0] dt_hi;
    logic [15:0] below;
    logic        main_put, want, stall;

    assign sh       = 6'(idx_reg) * 6'd3;
    assign thr      = 64'h2000 << sh;
    assign lowm     = (64'd1 << sh) - 64'd1;
    assign dt_hi    = dt_reg >> sh;
    assign below    = tmask_reg & ((16'd1 << idx_reg) - 16'd1);
    assign main_put = job_reg.has_inst && (job_reg.inst_slack == 4'd0);
    assign job_pop  = (state_reg == S_IDLE) && !job_empty;

    always_comb
    begin
        res  = '0;
        want = 1'b0;
        case (state_reg)
            S_HELD:
            begin
                want     = held_v_reg && ((tmask_reg != '0) || short_v_reg
                           || job_reg.has_inst || job_reg.wait_until);
                res      = held_reg;
                res.last = !((tmask_reg != '0) || short_v_reg || main_put);
            end
            S_WAIT:
            begin
                want            = tmask_reg[idx_reg];
                res.opcode      = OP_WAIT;
                res.delay_field = idx_reg;
                res.payload     = {16'b0, times_reg[idx_reg]};
                res.last        = (below == '0) && !short_v_reg && !main_put;
            end
            S_SHORT:
            begin
                want            = short_v_reg;
                res.opcode      = OP_WAIT2;
                res.delay_field = 4'd1;
                res.payload     = {21'b0, short_reg};
                res.last        = !main_put;
            end
            S_MAIN:
            begin
                want     = main_put;
                res      = job_reg.inst;
                res.last = 1'b1;
            end
            default:
            begin
                want = 1'b0;
            end
        endcase
    end

    assign stall    = want && res_full;
    assign res_push = want && !res_full;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SPLIT && dt_reg != '0 && dt_reg > {57'b0, slack_reg}
            && idx_reg != '0 && {3'b0, dt_reg} >= thr)
        begin
            times_reg[idx_reg] <= dt_hi[15:0];
        end
        else if (state_reg == S_SPLIT && dt_reg != '0 && dt_reg > {57'b0, slack_reg}
                 && idx_reg == '0)
        begin
            times_reg[0] <= dt_reg[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            job_reg     <= '0;
            dt_reg      <= '0;
            idx_reg     <= '0;
            tmask_reg   <= '0;
            short_reg   <= '0;
            short_v_reg <= 1'b0;
            held_reg    <= '0;
            held_v_reg  <= 1'b0;
            slack_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!job_empty)
                    begin
                        job_reg     <= job;
                        dt_reg      <= job.gap;
                        idx_reg     <= 4'd15;
                        tmask_reg   <= '0;
                        short_v_reg <= 1'b0;
                        state_reg   <= S_SPLIT;
                    end
                end
                S_SPLIT:
                begin
                    if (dt_reg == '0)
                    begin
                        idx_reg   <= 4'd15;
                        state_reg <= S_HELD;
                    end
                    else if (dt_reg <= {57'b0, slack_reg})
                    begin
                        slack_reg            <= slack_reg - dt_reg[3:0];
                        held_reg.delay_field <= held_reg.delay_field + dt_reg[3:0];
                        idx_reg              <= 4'd15;
                        state_reg            <= S_HELD;
                    end
                    else if (idx_reg != '0)
                    begin
                        if ({3'b0, dt_reg} >= thr)
                        begin
                            tmask_reg[idx_reg] <= 1'b1;
                            dt_reg             <= dt_reg & lowm[60:0];
                        end
                        idx_reg <= idx_reg - 4'd1;
                    end
                    else
                    begin
                        if (dt_reg <= 61'd2047 + {57'b0, slack_reg})
                        begin
                            held_reg.delay_field <= held_reg.delay_field + slack_reg;
                            slack_reg            <= '0;
                            short_reg            <= 11'(dt_reg - {57'b0, slack_reg});
                            short_v_reg          <= 1'b1;
                        end
                        else
                        begin
                            tmask_reg[0] <= 1'b1;
                        end
                        dt_reg    <= '0;
                        idx_reg   <= 4'd15;
                        state_reg <= S_HELD;
                    end
                end
                S_HELD:
                begin
                    if (!stall)
                    begin
                        if (want)
                        begin
                            held_v_reg <= 1'b0;
                            slack_reg  <= '0;
                        end
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (!stall)
                    begin
                        if (want)
                        begin
                            slack_reg <= '0;
                        end
                        if (idx_reg == '0)
                        begin
                            state_reg <= S_SHORT;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - 4'd1;
                        end
                    end
                end
                S_SHORT:
                begin
                    if (!stall)
                    begin
                        if (want)
                        begin
                            slack_reg <= '0;
                        end
                        state_reg <= S_MAIN;
                    end
                end
                S_MAIN:
                begin
                    if (!stall)
                    begin
                        if (job_reg.has_inst && job_reg.inst_slack != '0)
                        begin
                            held_reg   <= job_reg.inst;
                            held_v_reg <= 1'b1;
                            slack_reg  <= job_reg.inst_slack;
                        end
                        else
                        begin
                            slack_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "assert_macros.svh"

    `CHECK_IMPL(a_slack_needs_held, slack_reg != 4'd0, held_v_reg)
    `CHECK_IMPL(a_fold_bound, held_v_reg,
                ({1'b0, held_reg.delay_field} + {1'b0, slack_reg}) <= 5'd15)
    `CHECK_NEXT(a_pop_starts_split, job_pop, state_reg == S_SPLIT)

endmodule

// ----- tb/sv/tb_pulse_event_bytecode_encoder.sv -----
// testbench of the pulse event bytecode encoder: random and directed events,
// predicted instruction words checked in order by a scoreboard class
// depends on pebe_pkg and pulse_event_bytecode_encoder
module tb_pulse_event_bytecode_encoder;
    import pebe_pkg::*;

    localparam logic [2:0] CMD_NONE = 3'd7;
    localparam int NSYN = SYNTH_CHANNELS_DEF;
    localparam int NDAC = DAC_CHANNELS_DEF;
    localparam int IDLE_LIMIT = 4000;

    class enc_scoreboard;
        bit [31:0] mask;
        bit [63:0] now;
        bit [31:0] ttl;
        bit ttl_seen;
        bit [31:0] freq[NSYN];
        bit [31:0] amp[NSYN];
        bit freq_seen[NSYN];
        bit amp_seen[NSYN];
        bit [31:0] dac[NDAC];
        bit dac_seen[NDAC];
        int unsigned slack;
        result_t held;
        bit held_ok;
        result_t word_q[$];
        result_t step_q[$];
        int errors;

        function new();
            mask = 32'd1;
            now = '0;
            ttl = '0;
            ttl_seen = 0;
            foreach (freq[i])
            begin
                freq[i] = 0; amp[i] = 0; freq_seen[i] = 0; amp_seen[i] = 0;
            end
            foreach (dac[i])
            begin
                dac[i] = 0; dac_seen[i] = 0;
            end
            slack = 0;
            held = '0;
            held_ok = 0;
            errors = 0;
        endfunction

        function void put(result_t r);
            r.last = 1'b0;
            step_q.insert(step_q.size(), r);
        endfunction

        function void flush_held();
            if (held_ok)
            begin
                put(held);
                held_ok = 0;
            end
        endfunction

        function void add_inst(result_t r, int unsigned s);
            flush_held();
            slack = 0;
            if (s != 0)
            begin
                held = r;
                held_ok = 1;
                slack = s;
            end
            else
                put(r);
        endfunction

        function void fold(int unsigned t);
            slack -= t;
            held.delay_field += t[3:0];
        endfunction

        function void add_wait(bit [63:0] dt);
            bit [63:0] times[16];
            bit [63:0] short_w;
            result_t r;
            short_w = 0;
            foreach (times[i]) times[i] = 0;
            if (dt == 0)
                return;
            if (dt > {3'b0, GAP_MAX})
                dt = {3'b0, GAP_MAX};
            now += dt;
            if (dt <= slack)
            begin
                fold(dt[31:0]);
                return;
            end
            for (int i = 15; i >= 0; i--)
            begin
                if (i > 0)
                begin
                    if (dt < (64'h2000 << (3 * i)))
                        continue;
                end
                else if (dt <= 2047 + slack)
                begin
                    if (slack != 0)
                    begin
                        dt -= slack;
                        fold(slack);
                    end
                    short_w = dt;
                    break;
                end
                times[i] = dt >> (3 * i);
                dt -= times[i] << (3 * i);
                if (dt == 0)
                    break;
                if (dt <= slack)
                begin
                    fold(dt[31:0]);
                    break;
                end
            end
            for (int i = 15; i >= 0; i--)
            begin
                if (times[i] == 0)
                    continue;
                r = '0;
                r.opcode = OP_WAIT;
                r.delay_field = i[3:0];
                r.payload = {16'b0, times[i][15:0]};
                add_inst(r, 0);
            end
            if (short_w != 0)
            begin
                r = '0;
                r.opcode = OP_WAIT2;
                r.delay_field = 4'd1;
                r.payload = {21'b0, short_w[10:0]};
                add_inst(r, 0);
            end
        endfunction

        function void ttl_write(bit [63:0] gap, bit [31:0] v);
            bit [31:0] changes;
            bit [31:0] c;
            bit [4:0] bits[5];
            int n;
            result_t r;
            v &= mask;
            ttl &= mask;
            if (v == ttl && ttl_seen)
                return;
            add_wait(gap);
            now += 3;
            changes = ttl_seen ? (v ^ ttl) : v;
            ttl_seen = 1;
            ttl = v;
            n = $countones(changes);
            foreach (bits[k]) bits[k] = 0;
            if (n >= 1 && n <= 5)
            begin
                c = changes;
                for (int k = 0; k < 5; k++)
                begin
                    if (c != 0)
                    begin
                        for (int b = 0; b < 32; b++)
                            if (c[b])
                            begin
                                bits[k] = b[4:0];
                                break;
                            end
                        c &= c - 1;
                    end
                    else
                        bits[k] = bits[k - 1];
                end
            end
            r = '0;
            r.bit_a = bits[0];
            r.bit_b = bits[1];
            r.bit_c = bits[2];
            r.bit_d = bits[3];
            r.bit_e = bits[4];
            if (n == 1 || n == 2)
            begin
                r.opcode = OP_TTL2;
                r.bit_c = 0; r.bit_d = 0; r.bit_e = 0;
                add_inst(r, 3);
            end
            else if (n == 3 || n == 4)
            begin
                r.opcode = OP_TTL4;
                r.bit_e = 0;
                add_inst(r, 0);
            end
            else if (n == 5)
            begin
                r.opcode = OP_TTL5;
                add_inst(r, 7);
            end
            else
            begin
                r.opcode = OP_TTLALL;
                r.payload = v;
                add_inst(r, 15);
            end
        endfunction

        function void emit_chan(logic [3:0] op, bit [4:0] ch, bit [31:0] pay);
            result_t r;
            r = '0;
            r.opcode = op;
            r.chan_field = ch;
            r.payload = pay;
            add_inst(r, 0);
        endfunction

        function void note(item_t it);
            bit [63:0] gap;
            bit [31:0] v;
            bit [31:0] d;
            int ch;
            gap = (it.event_time > now) ? it.event_time - now : 0;
            ch = it.channel;
            step_q = {};
            case (it.cmd)
                CMD_TTL_WORD: ttl_write(gap, it.value & ~32'd1);
                CMD_TTL_BIT:
                    if (it.value != 0)
                        ttl_write(gap, ttl | (32'd1 << ch));
                    else
                        ttl_write(gap, ttl & ~(32'd1 << ch));
                CMD_FREQ:
                begin
                    v = (it.value > 32'h7fffffff) ? 32'h7fffffff : it.value;
                    if (ch < NSYN && !(freq_seen[ch] && v == freq[ch]))
                    begin
                        add_wait(gap);
                        now += 50;
                        d = v - freq[ch];
                        freq[ch] = v;
                        freq_seen[ch] = 1;
                        if (d <= 32'h3f || d >= 32'hffffffc0)
                            emit_chan(OP_FREQ_D7, ch[4:0], d & 32'h7f);
                        else if (d <= 32'h3fff || d >= 32'hffffc000)
                            emit_chan(OP_FREQ_D15, ch[4:0], d & 32'h7fff);
                        else if (d <= 32'h003fffff || d >= 32'hffc00000)
                            emit_chan(OP_FREQ_D23, ch[4:0], d & 32'h7fffff);
                        else
                            emit_chan(OP_FREQ, ch[4:0], v);
                    end
                end
                CMD_AMP:
                begin
                    v = (it.value > 4095) ? 4095 : it.value;
                    if (ch < NSYN && !(amp_seen[ch] && v == amp[ch]))
                    begin
                        add_wait(gap);
                        now += 50;
                        d = (v - amp[ch]) & 32'hffff;
                        amp[ch] = v;
                        amp_seen[ch] = 1;
                        if (d <= 32'h3f || d >= 32'hffc0)
                            emit_chan(OP_AMP_D7, ch[4:0], d & 32'h7f);
                        else
                            emit_chan(OP_AMP, ch[4:0], v);
                    end
                end
                CMD_DAC:
                begin
                    v = (it.value > 32'hffff) ? 32'hffff : it.value;
                    if (ch < NDAC && !(dac_seen[ch] && v == dac[ch]))
                    begin
                        add_wait(gap);
                        now += 45;
                        d = (v - dac[ch]) & 32'hffff;
                        dac[ch] = v;
                        dac_seen[ch] = 1;
                        if (d <= 32'h1ff || d >= 32'hfe00)
                            emit_chan(OP_DAC_D10, ch[4:0], d & 32'h3ff);
                        else
                            emit_chan(OP_DAC, ch[4:0], v);
                    end
                end
                CMD_CLOCK:
                begin
                    add_wait(gap);
                    now += 5;
                    emit_chan(OP_CLOCK, 5'd0, (it.value - 1) & 32'hff);
                end
                CMD_WAIT_UNTIL:
                begin
                    add_wait(gap);
                    flush_held();
                    slack = 0;
                end
                default: ;
            endcase
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            word_q = {word_q, step_q};
        endfunction

        function void cmp(string name, bit [31:0] e, bit [31:0] a);
            if (e != a)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
                errors++;
            end
        endfunction

        function void check(result_t r);
            result_t e;
            if (word_q.size() == 0)
            begin
                $error("unexpected word opcode %0d", r.opcode);
                errors++;
                return;
            end
            e = word_q.pop_front();
            cmp("opcode", e.opcode, r.opcode);
            cmp("delay_field", e.delay_field, r.delay_field);
            cmp("chan_field", e.chan_field, r.chan_field);
            cmp("payload", e.payload, r.payload);
            cmp("bit_a", e.bit_a, r.bit_a);
            cmp("bit_b", e.bit_b, r.bit_b);
            cmp("bit_c", e.bit_c, r.bit_c);
            cmp("bit_d", e.bit_d, r.bit_d);
            cmp("bit_e", e.bit_e, r.bit_e);
            cmp("last", e.last, r.last);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    item_t item;
    logic push;
    logic full;
    logic mask_we;
    logic [31:0] mask_wdata;
    result_t result;
    logic empty;
    logic pop;

    enc_scoreboard sb;
    int idle_cycles;

    pulse_event_bytecode_encoder u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item(item),
        .push(push),
        .full(full),
        .mask_we(mask_we),
        .mask_wdata(mask_wdata),
        .result(result),
        .empty(empty),
        .pop(pop)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side with random stalls
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, 6);
            repeat (stall)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            sb.check(result);
        end
    end

    task automatic send(logic [2:0] cmd, bit rel, bit [63:0] tv, logic [4:0] ch,
                        logic [31:0] v);
        item_t it;
        int gap;
        gap = $urandom_range(0, 6);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        it.cmd = cmd;
        it.event_time = rel ? sb.now + tv : tv;
        it.channel = ch;
        it.value = v;
        item <= it;
        push <= 1'b1;
        do @(posedge clk); while (full);
        sb.note(it);
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.word_q.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_mask(bit [31:0] m);
        drain();
        mask_we <= 1'b1;
        mask_wdata <= m;
        @(negedge clk);
        mask_we <= 1'b0;
        sb.mask = m;
    endtask

    function automatic bit [31:0] near(bit [31:0] base);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return base + $urandom_range(0, 128) - 64;
            2: return base + $urandom_range(0, 32767) - 16384;
            default: return base + $urandom_range(0, 1 << 23) - (1 << 22);
        endcase
    endfunction

    task automatic random_item();
        logic [2:0] cmd;
        bit [63:0] tv;
        bit rel;
        int r;
        int ch;
        bit [31:0] v;
        r = $urandom_range(0, 99);
        cmd = r < 22 ? CMD_TTL_WORD : r < 44 ? CMD_TTL_BIT : r < 60 ? CMD_FREQ :
              r < 72 ? CMD_AMP : r < 84 ? CMD_DAC : r < 90 ? CMD_CLOCK :
              r < 98 ? CMD_WAIT_UNTIL : CMD_NONE;
        rel = 1;
        r = $urandom_range(0, 99);
        if (r < 65)
            tv = $urandom_range(0, 20);
        else if (r < 88)
            tv = $urandom_range(0, 5000);
        else if (r < 94)
            tv = {24'b0, 8'($urandom), 32'($urandom)};
        else if (r < 96)
            tv = {32'($urandom), 32'($urandom)};
        else
        begin
            rel = 0;
            tv = sb.now - $urandom_range(0, 100);
        end
        ch = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) :
             cmd == CMD_DAC ? $urandom_range(0, NDAC - 1) :
             cmd == CMD_TTL_BIT ? $urandom_range(0, 31) : $urandom_range(0, NSYN - 1);
        case (cmd)
            CMD_TTL_WORD:
            begin
                v = sb.ttl;
                repeat ($urandom_range(0, 7)) v[$urandom_range(0, 31)] ^= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    v = $urandom;
            end
            CMD_TTL_BIT: v = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1);
            CMD_FREQ: v = near(ch < NSYN ? sb.freq[ch] : 0);
            CMD_AMP: v = $urandom_range(0, 3) == 0 ? $urandom :
                         near(ch < NSYN ? sb.amp[ch] : 0) & 32'h1fff;
            CMD_DAC: v = $urandom_range(0, 3) == 0 ? $urandom :
                         near(ch < NDAC ? sb.dac[ch] : 0) & 32'h1ffff;
            default: v = $urandom;
        endcase
        send(cmd, rel, tv, ch[4:0], v);
    endtask

    initial
    begin
        bit [31:0] masks[4];
        sb = new();
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        mask_we = 1'b0;
        mask_wdata = '0;
        item = '0;
        idle_cycles = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        write_mask(32'hffffffff);
        send(CMD_TTL_WORD, 1, 0, 5'd0, 32'h0);
        send(CMD_TTL_WORD, 1, 5, 5'd0, 32'h6);
        send(CMD_TTL_BIT, 1, 2000, 5'd31, 32'h1);
        send(CMD_TTL_WORD, 1, 0, 5'd0, 32'h8000_0006);
        send(CMD_TTL_WORD, 1, 3, 5'd0, 32'h8000_0036);
        send(CMD_TTL_WORD, 1, 1, 5'd0, 32'h8000_0fc6);
        send(CMD_TTL_WORD, 1, 9, 5'd0, 32'hffff_ffff);
        send(CMD_TTL_WORD, 1, 9, 5'd0, 32'hffff_fffe);
        send(CMD_TTL_BIT, 1, 0, 5'd3, 32'h0);
        send(CMD_TTL_BIT, 1, 4, 5'd3, 32'h0);
        send(CMD_FREQ, 1, 3000, 5'd0, 32'hffff_ffff);
        send(CMD_FREQ, 1, 0, 5'd0, 32'h7fff_ffc1);
        send(CMD_FREQ, 1, 0, 5'd21, 32'h0040_0000);
        send(CMD_FREQ, 1, 0, 5'd22, 32'h5);
        send(CMD_FREQ, 1, 0, 5'd21, 32'h0040_0000);
        send(CMD_AMP, 1, 10, 5'd0, 32'd5000);
        send(CMD_AMP, 1, 10, 5'd0, 32'd4000);
        send(CMD_DAC, 1, 10, 5'd3, 32'hffff_ffff);
        send(CMD_DAC, 1, 10, 5'd3, 32'hfff0);
        send(CMD_DAC, 1, 10, 5'd4, 32'h1);
        send(CMD_CLOCK, 1, 0, 5'd0, 32'h0);
        send(CMD_CLOCK, 1, 70000, 5'd0, 32'hffff_ffff);
        send(CMD_TTL_BIT, 1, 0, 5'd7, 32'h1);
        send(CMD_WAIT_UNTIL, 1, 10, 5'd0, 32'h0);
        send(CMD_CLOCK, 0, 64'h0, 5'd0, 32'h10);
        send(CMD_WAIT_UNTIL, 0, 64'hffff_ffff_ffff_ffff, 5'd0, 32'h0);
        send(CMD_NONE, 1, 100, 5'd31, 32'hffff_ffff);

        masks[0] = 32'h0;
        masks[1] = $urandom;
        masks[2] = 32'h0000_ffff;
        masks[3] = 32'hffff_ffff;
        foreach (masks[p])
        begin
            write_mask(masks[p]);
            repeat (55) random_item();
        end
        write_mask(32'h1);
        repeat (15) random_item();

        drain();
        if (sb.errors == 0 && sb.word_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pebe_pkg.sv
hw/rtl/pebe_fifo.sv
hw/rtl/pebe_front.sv
hw/rtl/pebe_back.sv
hw/rtl/pulse_event_bytecode_encoder.sv
tb/sv/tb_pulse_event_bytecode_encoder.sv
